FILE: sv/sll_pkg.sv
// Shared types and constants for the singly linked list engine.
// No dependencies; every other file imports this package.
`default_nettype none

package sll_pkg;

   localparam int DEFAULT_LIST_DEPTH = 32;
   localparam int MAX_RESULTS        = 32;
   localparam int BEAT_W             = $clog2(MAX_RESULTS);

   typedef enum logic [2:0] {
      ACT_FRONT     = 3'd0,
      ACT_AFTER     = 3'd1,
      ACT_APPEND    = 3'd2,
      ACT_DEL_VALUE = 3'd3,
      ACT_DEL_NTH   = 3'd4,
      ACT_DUMP      = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_BAD_POS   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_FIND,
      S_TAIL,
      S_NTH,
      S_POP,
      S_LINK,
      S_UNLINK,
      S_FREE,
      S_DUMP,
      S_RESP
   } state_type;

   typedef struct packed {
      logic val_we;
      logic link_we;
   } mem_we_type;

   typedef struct packed {
      status_type  status;
      logic [5:0]  length;
      logic        item_valid;
      logic [31:0] item;
      logic        last;
   } rsp_beat_type;

endpackage

`default_nettype wire

FILE: sv/sll_store.sv
// Node store: value memory and link memory, one read and one write port each.
// Read data is registered. Depends on sll_pkg.
`default_nettype none

module sll_store
   import sll_pkg::*;
#(
   parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
   localparam int ADDR_W = $clog2(LIST_DEPTH),
   localparam int IDX_W  = $clog2(LIST_DEPTH + 1)
)(
   input  wire logic              clock,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [31:0]       rd_value,
   output logic      [IDX_W-1:0]  rd_link,
   input  wire mem_we_type        wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [31:0]       wr_value,
   input  wire logic [IDX_W-1:0]  wr_link
);

   logic [31:0]      value_mem_ff [LIST_DEPTH];
   logic [IDX_W-1:0] link_mem_ff  [LIST_DEPTH];
   logic [31:0]      rd_value_ff;
   logic [IDX_W-1:0] rd_link_ff;

   always_ff @(posedge clock) begin
      if (wr_en.val_we) begin
         value_mem_ff[wr_addr] <= wr_value;
      end
      rd_value_ff <= value_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en.link_we) begin
         link_mem_ff[wr_addr] <= wr_link;
      end
      rd_link_ff <= link_mem_ff[rd_addr];
   end

   assign rd_value = rd_value_ff;
   assign rd_link  = rd_link_ff;

endmodule

`default_nettype wire

FILE: sv/sll_ctrl.sv
// List sequencer: walks the node store one node a cycle, dumps only on beat_ok;
// commits head, free chain and count. Depends on sll_pkg and drives sll_store.
`default_nettype none

module sll_ctrl
   import sll_pkg::*;
#(
   parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH,
   localparam int ADDR_W = $clog2(LIST_DEPTH),
   localparam int IDX_W  = $clog2(LIST_DEPTH + 1)
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [2:0]        req_action,
   input  wire logic [31:0]       req_value,
   input  wire logic [31:0]       req_key,
   input  wire logic [5:0]        req_position,
   output rsp_beat_type           beat,
   output logic                   beat_load,
   input  wire logic              beat_ok,
   output logic      [ADDR_W-1:0] rd_addr,
   input  wire logic [31:0]       rd_value,
   input  wire logic [IDX_W-1:0]  rd_link,
   output mem_we_type             wr_en,
   output logic      [ADDR_W-1:0] wr_addr,
   output logic      [31:0]       wr_value,
   output logic      [IDX_W-1:0]  wr_link
);

   localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(LIST_DEPTH);

   state_type          state_ff,  state_in;
   logic [IDX_W-1:0]   head_ff,   head_in;
   logic [IDX_W-1:0]   free_ff,   free_in;
   logic [IDX_W-1:0]   count_ff,  count_in;
   logic [IDX_W-1:0]   cur_ff,    cur_in;
   logic [IDX_W-1:0]   prev_ff,   prev_in;
   logic [IDX_W-1:0]   nxt_ff,    nxt_in;
   logic [IDX_W-1:0]   new_ff,    new_in;
   logic [IDX_W-1:0]   steps_ff,  steps_in;
   logic [IDX_W-1:0]   target_ff, target_in;
   logic [BEAT_W-1:0]  beat_cnt_ff, beat_cnt_in;
   logic [ADDR_W-1:0]  init_ff,   init_in;
   action_type         act_ff,    act_in;
   logic [31:0]        val_ff,    val_in;
   logic [31:0]        match_ff,  match_in;
   status_type         status_ff, status_in;
   action_type         req_act;
   logic               dump_last;

   assign req_act = action_type'(req_action);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         head_ff  <= NULL_IDX;
         free_ff  <= '0;
         count_ff <= '0;
         init_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         free_ff  <= free_in;
         count_ff <= count_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      nxt_ff      <= nxt_in;
      new_ff      <= new_in;
      steps_ff    <= steps_in;
      target_ff   <= target_in;
      beat_cnt_ff <= beat_cnt_in;
      act_ff      <= act_in;
      val_ff      <= val_in;
      match_ff    <= match_in;
      status_ff   <= status_in;
   end

   assign dump_last = (rd_link >= NULL_IDX) || (beat_cnt_ff == BEAT_W'(MAX_RESULTS - 1));

   always_comb begin
      state_in    = state_ff;
      head_in     = head_ff;
      free_in     = free_ff;
      count_in    = count_ff;
      init_in     = init_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      nxt_in      = nxt_ff;
      new_in      = new_ff;
      steps_in    = steps_ff;
      target_in   = target_ff;
      beat_cnt_in = beat_cnt_ff;
      act_in      = act_ff;
      val_in      = val_ff;
      match_in    = match_ff;
      status_in   = status_ff;

      req_stall   = 1'b1;
      rd_addr     = cur_ff[ADDR_W-1:0];
      wr_en       = '0;
      wr_addr     = cur_ff[ADDR_W-1:0];
      wr_value    = val_ff;
      wr_link     = NULL_IDX;

      beat_load       = 1'b0;
      beat.status     = status_ff;
      beat.length     = 6'(count_ff);
      beat.item_valid = 1'b0;
      beat.item       = '0;
      beat.last       = 1'b1;

      case (state_ff)
         S_INIT: begin
            // chain every node into the free list
            wr_en.link_we = 1'b1;
            wr_addr       = init_ff;
            wr_link       = IDX_W'(init_ff) + IDX_W'(1);
            if (init_ff == ADDR_W'(LIST_DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               init_in = init_ff + ADDR_W'(1);
            end
         end

         S_IDLE: begin
            req_stall = 1'b0;
            rd_addr   = head_ff[ADDR_W-1:0];
            if (req_valid) begin
               act_in      = req_act;
               val_in      = req_value;
               match_in    = (req_act == ACT_AFTER) ? req_key : req_value;
               status_in   = ST_OK;
               cur_in      = head_ff;
               prev_in     = NULL_IDX;
               steps_in    = '0;
               beat_cnt_in = '0;
               target_in   = IDX_W'(8'(count_ff) - 8'(req_position));
               case (req_act)
                  ACT_FRONT: begin
                     if (free_ff >= NULL_IDX) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        rd_addr  = free_ff[ADDR_W-1:0];
                        state_in = S_POP;
                     end
                  end
                  ACT_AFTER, ACT_DEL_VALUE: begin
                     state_in = S_FIND;
                  end
                  ACT_APPEND: begin
                     if (free_ff >= NULL_IDX) begin
                        status_in = ST_FULL;
                        state_in  = S_RESP;
                     end else if (head_ff >= NULL_IDX) begin
                        rd_addr  = free_ff[ADDR_W-1:0];
                        state_in = S_POP;
                     end else begin
                        state_in = S_TAIL;
                     end
                  end
                  ACT_DEL_NTH: begin
                     if (req_position == 6'd0 || 8'(req_position) > 8'(count_ff)) begin
                        status_in = ST_BAD_POS;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_NTH;
                     end
                  end
                  ACT_DUMP: begin
                     state_in = (head_ff >= NULL_IDX) ? S_RESP : S_DUMP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         S_FIND: begin
            if (cur_ff >= NULL_IDX) begin
               status_in = ST_NOT_FOUND;
               state_in  = S_RESP;
            end else if (rd_value == match_ff) begin
               nxt_in = rd_link;
               if (act_ff == ACT_AFTER) begin
                  if (free_ff >= NULL_IDX) begin
                     status_in = ST_FULL;
                     state_in  = S_RESP;
                  end else begin
                     rd_addr  = free_ff[ADDR_W-1:0];
                     state_in = S_POP;
                  end
               end else if (prev_ff >= NULL_IDX) begin
                  head_in  = rd_link;
                  state_in = S_FREE;
               end else begin
                  state_in = S_UNLINK;
               end
            end else begin
               prev_in = cur_ff;
               cur_in  = rd_link;
               rd_addr = rd_link[ADDR_W-1:0];
            end
         end

         S_TAIL: begin
            if (rd_link >= NULL_IDX) begin
               rd_addr  = free_ff[ADDR_W-1:0];
               state_in = S_POP;
            end else begin
               cur_in  = rd_link;
               rd_addr = rd_link[ADDR_W-1:0];
            end
         end

         S_NTH: begin
            if (steps_ff == target_ff) begin
               nxt_in = rd_link;
               if (prev_ff >= NULL_IDX) begin
                  head_in  = rd_link;
                  state_in = S_FREE;
               end else begin
                  state_in = S_UNLINK;
               end
            end else begin
               prev_in  = cur_ff;
               cur_in   = rd_link;
               rd_addr  = rd_link[ADDR_W-1:0];
               steps_in = steps_ff + IDX_W'(1);
            end
         end

         S_POP: begin
            // rd_link holds the successor of the free head
            wr_en.val_we  = 1'b1;
            wr_en.link_we = 1'b1;
            wr_addr       = free_ff[ADDR_W-1:0];
            new_in        = free_ff;
            free_in       = rd_link;
            count_in      = count_ff + IDX_W'(1);
            case (act_ff)
               ACT_FRONT: begin
                  wr_link  = head_ff;
                  head_in  = free_ff;
                  state_in = S_RESP;
               end
               ACT_AFTER: begin
                  wr_link  = nxt_ff;
                  state_in = S_LINK;
               end
               default: begin
                  wr_link = NULL_IDX;
                  if (cur_ff >= NULL_IDX) begin
                     head_in  = free_ff;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_LINK;
                  end
               end
            endcase
         end

         S_LINK: begin
            wr_en.link_we = 1'b1;
            wr_addr       = cur_ff[ADDR_W-1:0];
            wr_link       = new_ff;
            state_in      = S_RESP;
         end

         S_UNLINK: begin
            wr_en.link_we = 1'b1;
            wr_addr       = prev_ff[ADDR_W-1:0];
            wr_link       = nxt_ff;
            state_in      = S_FREE;
         end

         S_FREE: begin
            // push the removed node onto the free chain
            wr_en.link_we = 1'b1;
            wr_addr       = cur_ff[ADDR_W-1:0];
            wr_link       = free_ff;
            free_in       = cur_ff;
            if (count_ff != '0) begin
               count_in = count_ff - IDX_W'(1);
            end
            state_in = S_RESP;
         end

         S_DUMP: begin
            beat.status     = ST_OK;
            beat.item_valid = 1'b1;
            beat.item       = rd_value;
            beat.last       = dump_last;
            if (beat_ok) begin
               beat_load = 1'b1;
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  cur_in      = rd_link;
                  rd_addr     = rd_link[ADDR_W-1:0];
                  beat_cnt_in = beat_cnt_ff + BEAT_W'(1);
               end
            end
         end

         S_RESP: begin
            if (beat_ok) begin
               beat_load = 1'b1;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/singly_linked_list_engine.sv
// Singly linked list engine over a pool of LIST_DEPTH nodes; uses sll_pkg, sll_ctrl, sll_store.
// One item at a time: req_stall stays high from an accepted request until its last result
// beat is loaded. Walks go one node per cycle through the link memory read port; dump beats
// leave one per cycle while rsp_stall is low.
// Reset (synchronous): chains the free pool with req_stall held high.
`default_nettype none

module singly_linked_list_engine
   import sll_pkg::*;
#(
   parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_action,
   input  wire logic signed [31:0] req_value,
   input  wire logic signed [31:0] req_key,
   input  wire logic [5:0]  req_position,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [5:0]       rsp_length,
   output logic             rsp_item_valid,
   output logic signed [31:0] rsp_item,
   output logic             rsp_last
);

   localparam int ADDR_W = $clog2(LIST_DEPTH);
   localparam int IDX_W  = $clog2(LIST_DEPTH + 1);

   // store port between sequencer and node memories
   logic [ADDR_W-1:0] rd_addr;
   logic [31:0]       rd_value;
   logic [IDX_W-1:0]  rd_link;
   mem_we_type        wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [31:0]       wr_value;
   logic [IDX_W-1:0]  wr_link;

   // result beat from the sequencer into the output register
   rsp_beat_type beat;
   logic         beat_load;
   logic         beat_ok;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_beat_ff;

   sll_ctrl #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_value    (req_value),
      .req_key      (req_key),
      .req_position (req_position),
      .beat         (beat),
      .beat_load    (beat_load),
      .beat_ok      (beat_ok),
      .rd_addr      (rd_addr),
      .rd_value     (rd_value),
      .rd_link      (rd_link),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_value     (wr_value),
      .wr_link      (wr_link)
   );

   // All writes of one item finish before the next item issues a read, so the
   // store needs no forwarding: the sequencer interlocks by state order.
   sll_store #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_store (
      .clock    (clock),
      .rd_addr  (rd_addr),
      .rd_value (rd_value),
      .rd_link  (rd_link),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_value (wr_value),
      .wr_link  (wr_link)
   );

   // Output register: take a new beat when empty or when the held beat leaves.
   assign beat_ok = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (beat_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the payload while stalled
   always_ff @(posedge clock) begin
      if (beat_load) begin
         rsp_beat_ff <= beat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_beat_ff.status;
   assign rsp_length     = rsp_beat_ff.length;
   assign rsp_item_valid = rsp_beat_ff.item_valid;
   assign rsp_item       = rsp_beat_ff.item;
   assign rsp_last       = rsp_beat_ff.last;

endmodule

`default_nettype wire

FILE: sv/sll_checker.sv
// Port-level checks of the list engine, bound to singly_linked_list_engine.
// Depends on sll_pkg for the status codes.
`default_nettype none

module sll_checker
   import sll_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_item_valid,
   input wire logic [31:0] rsp_item,
   input wire logic        rsp_last
);

   // one item at a time: busy right after a request is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while an item was in progress");

   // a beat without a list element closes its item and carries zero
   a_plain_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item_valid |-> rsp_last && rsp_item == 32'd0)
      else $error("plain result beat not final or item not zero");

   // error status never comes with a dumped element
   a_error_no_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_item_valid)
      else $error("error status on a dump beat");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item) && $stable(rsp_last))
      else $error("stalled result beat changed");

endmodule

bind singly_linked_list_engine sll_checker u_sll_checker (.*);

`default_nettype wire
